// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants for the first-fit heap allocator: defaults, op and status
// codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // default geometry
  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int MIN_PAYLOAD_DEF  = 4;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int REQ_W     = 13;
  localparam int LENGTH_W  = 13;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = 1'b1;

  // register reset values
  localparam logic [ADDR_W-1:0]   RESET_HEAP_BASE   = 32'd4096;
  localparam logic [LENGTH_W-1:0] RESET_HEAP_LENGTH = 13'd4096;

endpackage

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap allocator with coalescing. Block headers live in a header
// RAM indexed by heap word; a small sequencer walks the header chain one
// header per cycle.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  op, request_bytes, release_address
//   out_     output     out_valid / out_stall granted_address, status
//   cfg_     input      cfg_valid / cfg_ready index, data (heap_base, heap_length)
//
// Steps: allocate visits headers until one fits, then splits it or marks it
//   used; free walks headers up to the target, may merge forward, writes it and
//   may merge back; a bad free is ignored. Each hands its word to the output
//   register in hand-off; one header per cycle through the header RAM read port.
// Reset and any register write rebuild the heap (BUILD0, BUILD1); requests stall.
// A stalled output word holds the sequencer in hand-off; a new request is
//   taken while the previous word still waits.
//
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int MIN_PAYLOAD  = ffha_pkg::MIN_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [ffha_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]    in_release_address,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]    out_granted_address,
  output logic [ffha_pkg::STATUS_W-1:0]  out_status,
  // register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int HDR_SPAN = (HEADER_BYTES + 3) / 4 * 4;
  localparam int WORDS    = HEAP_BYTES / 4;
  localparam int IDX_W    = $clog2(WORDS);
  localparam int SIZE_W   = $clog2(HEAP_BYTES + 1);
  localparam int ENT_W    = SIZE_W + IDX_W + 2;
  localparam int LEN_W    = ((SIZE_W > 14) ? SIZE_W : 14) + 2;

  localparam logic [LEN_W-1:0] HDR_L     = LEN_W'(HDR_SPAN);
  localparam logic [LEN_W-1:0] TWO_HDR   = LEN_W'(2 * HDR_SPAN);
  localparam logic [LEN_W-1:0] SPLIT_MIN = LEN_W'(HDR_SPAN + MIN_PAYLOAD);
  localparam logic [LEN_W-1:0] CAP_L     = LEN_W'(WORDS * 4);
  localparam logic [LEN_W-1:0] WORDS_L   = LEN_W'(WORDS);
  localparam logic [LEN_W-1:0] ROUND_L   = LEN_W'(3);

  localparam logic [3:0] ST_BUILD0 = 4'd0;
  localparam logic [3:0] ST_BUILD1 = 4'd1;
  localparam logic [3:0] ST_IDLE   = 4'd2;
  localparam logic [3:0] ST_A_CHK  = 4'd3;
  localparam logic [3:0] ST_A_WP   = 4'd4;
  localparam logic [3:0] ST_F_WALK = 4'd5;
  localparam logic [3:0] ST_F_FWD  = 4'd6;
  localparam logic [3:0] ST_F_WT   = 4'd7;
  localparam logic [3:0] ST_F_WP   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]                    state_r, state_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic [ffha_pkg::LENGTH_W-1:0] len_r, len_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   pbase_r, pbase_nxt;
  logic [IDX_W-1:0]              cur_r, cur_nxt;
  logic [IDX_W-1:0]              prev_r, prev_nxt;
  logic [IDX_W-1:0]              tgt_r, tgt_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          prev_used_r, prev_used_nxt;
  logic [SIZE_W-1:0]             prev_size_r, prev_size_nxt;
  logic [SIZE_W-1:0]             t_size_r, t_size_nxt;
  logic                          t_link_r, t_link_nxt;
  logic [IDX_W-1:0]              t_next_r, t_next_nxt;
  logic [LEN_W-1:0]              need_r, need_nxt;
  logic [LEN_W-1:0]              need_words_r, need_words_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic [ffha_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ffha_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [ffha_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic              rd_used, rd_link;
  logic [SIZE_W-1:0] rd_size;
  logic [IDX_W-1:0]  rd_next;

  logic                        in_accept, cfg_we;
  logic [LEN_W-1:0]            len_up, len_cap, len_eff, need_in;
  logic [IDX_W-1:0]            endw;
  logic [SIZE_W-1:0]           size0;
  logic [ffha_pkg::ADDR_W-1:0] rel_off;
  logic                        rel_bad;
  logic [LEN_W-1:0]            rd_size_l, rest, nw_l;
  logic                        fit, do_split;
  logic [LEN_W-1:0]            t_end, p_end;
  logic                        fwd_merge, back_merge;

  ffha_ram #(
    .WIDTH(ENT_W),
    .DEPTH(WORDS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // header layout: used | size | link valid | next
  assign rd_used = ram_rdata[ENT_W-1];
  assign rd_size = ram_rdata[ENT_W-2 -: SIZE_W];
  assign rd_link = ram_rdata[IDX_W];
  assign rd_next = ram_rdata[IDX_W-1:0];

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // effective heap length and initial headers
  assign len_up  = (LEN_W'(len_r) + ROUND_L) & ~ROUND_L;
  assign len_cap = (len_up > CAP_L) ? CAP_L : len_up;
  assign len_eff = (len_cap < TWO_HDR) ? TWO_HDR : len_cap;
  assign endw    = IDX_W'((len_eff - HDR_L) >> 2);
  assign size0   = SIZE_W'(len_eff - TWO_HDR);

  // request decode
  assign need_in = (LEN_W'(in_request_bytes) + ROUND_L) & ~ROUND_L;
  assign rel_off = in_release_address - pbase_r;
  assign rel_bad = (in_release_address == '0) || (rel_off[1:0] != 2'b00) ||
                   ({2'b00, rel_off[ffha_pkg::ADDR_W-1:2]} >= ffha_pkg::ADDR_W'(WORDS));

  // allocate fit and split
  assign rd_size_l = LEN_W'(rd_size);
  assign fit       = !rd_used && (rd_size_l >= need_r);
  assign rest      = rd_size_l - need_r;
  assign nw_l      = LEN_W'(cur_r) + need_words_r;
  assign do_split  = (rest >= SPLIT_MIN) && (nw_l < WORDS_L);

  // merge adjacency (byte offsets within the heap)
  assign t_end      = LEN_W'({tgt_r, 2'b00}) + HDR_L + LEN_W'(t_size_r);
  assign fwd_merge  = !rd_used && (t_end == LEN_W'({t_next_r, 2'b00}));
  assign p_end      = LEN_W'({prev_r, 2'b00}) + HDR_L + LEN_W'(prev_size_r);
  assign back_merge = have_prev_r && !prev_used_r && (p_end == LEN_W'({tgt_r, 2'b00}));

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    len_nxt        = len_r;
    pbase_nxt      = pbase_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    tgt_nxt        = tgt_r;
    have_prev_nxt  = have_prev_r;
    prev_used_nxt  = prev_used_r;
    prev_size_nxt  = prev_size_r;
    t_size_nxt     = t_size_r;
    t_link_nxt     = t_link_r;
    t_next_nxt     = t_next_r;
    need_nxt       = need_r;
    need_words_nxt = need_words_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      ST_BUILD0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b0, size0, 1'b1, endw};
        pbase_nxt = base_r + ffha_pkg::ADDR_W'(HDR_SPAN);
        state_nxt = ST_BUILD1;
      end
      ST_BUILD1: begin
        ram_we    = 1'b1;
        ram_waddr = endw;
        ram_wdata = {1'b1, {SIZE_W{1'b0}}, 1'b0, {IDX_W{1'b0}}};
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        // read port parked on the start header, so its data is ready next cycle
        if (in_accept) begin
          cur_nxt       = '0;
          have_prev_nxt = 1'b0;
          res_addr_nxt  = '0;
          if (in_op == ffha_pkg::OP_ALLOC) begin
            need_nxt       = need_in;
            need_words_nxt = (HDR_L + need_in) >> 2;
            state_nxt      = ST_A_CHK;
          end else if (rel_bad) begin
            res_status_nxt = ffha_pkg::STATUS_IGNORED;
            state_nxt      = ST_DONE;
          end else begin
            tgt_nxt   = rel_off[IDX_W+1:2];
            state_nxt = ST_F_WALK;
          end
        end
      end
      ST_A_CHK: begin
        if (fit) begin
          res_addr_nxt   = pbase_r + ffha_pkg::ADDR_W'({cur_r, 2'b00});
          res_status_nxt = ffha_pkg::STATUS_DONE;
          if (do_split) begin
            ram_we     = 1'b1;
            ram_waddr  = IDX_W'(nw_l);
            ram_wdata  = {1'b0, SIZE_W'(rest - HDR_L), rd_link, rd_next};
            t_next_nxt = IDX_W'(nw_l);
            state_nxt  = ST_A_WP;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cur_r;
            ram_wdata = {1'b1, rd_size, rd_link, rd_next};
            state_nxt = ST_DONE;
          end
        end else if (!rd_link) begin
          res_addr_nxt   = '0;
          res_status_nxt = ffha_pkg::STATUS_OOM;
          state_nxt      = ST_DONE;
        end else begin
          cur_nxt   = rd_next;
          ram_raddr = rd_next;
        end
      end
      ST_A_WP: begin
        // shrink the taken block and link it to the split-off remainder
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {1'b1, SIZE_W'(need_r), 1'b1, t_next_r};
        state_nxt = ST_DONE;
      end
      ST_F_WALK: begin
        if (cur_r == tgt_r) begin
          t_size_nxt = rd_size;
          t_link_nxt = rd_link;
          t_next_nxt = rd_next;
          if (rd_link) begin
            ram_raddr = rd_next;
            state_nxt = ST_F_FWD;
          end else begin
            state_nxt = ST_F_WT;
          end
        end else if (!rd_link) begin
          res_status_nxt = ffha_pkg::STATUS_IGNORED;
          state_nxt      = ST_DONE;
        end else begin
          prev_nxt      = cur_r;
          prev_used_nxt = rd_used;
          prev_size_nxt = rd_size;
          have_prev_nxt = 1'b1;
          cur_nxt       = rd_next;
          ram_raddr     = rd_next;
        end
      end
      ST_F_FWD: begin
        if (fwd_merge) begin
          t_size_nxt = SIZE_W'(LEN_W'(t_size_r) + HDR_L + rd_size_l);
          t_link_nxt = rd_link;
          t_next_nxt = rd_next;
        end
        state_nxt = ST_F_WT;
      end
      ST_F_WT: begin
        ram_we         = 1'b1;
        ram_waddr      = tgt_r;
        ram_wdata      = {1'b0, t_size_r, t_link_r, t_next_r};
        res_status_nxt = ffha_pkg::STATUS_DONE;
        state_nxt      = back_merge ? ST_F_WP : ST_DONE;
      end
      ST_F_WP: begin
        ram_we    = 1'b1;
        ram_waddr = prev_r;
        ram_wdata = {1'b0, SIZE_W'(LEN_W'(prev_size_r) + HDR_L + LEN_W'(t_size_r)),
                     t_link_r, t_next_r};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a register write rebuilds the heap
    if (cfg_we) begin
      case (cfg_index)
        ffha_pkg::CFG_HEAP_BASE: begin
          base_nxt  = cfg_data;
          state_nxt = ST_BUILD0;
        end
        ffha_pkg::CFG_HEAP_LENGTH: begin
          len_nxt   = cfg_data[ffha_pkg::LENGTH_W-1:0];
          state_nxt = ST_BUILD0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD0;
      base_r      <= ffha_pkg::RESET_HEAP_BASE;
      len_r       <= ffha_pkg::RESET_HEAP_LENGTH;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      len_r       <= len_nxt;
      have_prev_r <= have_prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pbase_r      <= pbase_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    tgt_r        <= tgt_nxt;
    prev_used_r  <= prev_used_nxt;
    prev_size_r  <= prev_size_nxt;
    t_size_r     <= t_size_nxt;
    t_link_r     <= t_link_nxt;
    t_next_r     <= t_next_nxt;
    need_r       <= need_nxt;
    need_words_r <= need_words_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

`ifndef SYNTH
  // the header chain is address ordered: every followed link points forward
  a_chain_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_A_CHK || state_r == ST_F_WALK) && rd_link) |-> (rd_next > cur_r))
    else $error("header chain link does not point forward");

  // a result word appears only out of the hand-off state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word raised outside hand-off");

  // a null free goes straight to hand-off as ignored
  a_null_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !cfg_we && in_op == ffha_pkg::OP_FREE && in_release_address == '0)
    |=> (state_r == ST_DONE && res_status_r == ffha_pkg::STATUS_IGNORED))
    else $error("null free not answered as ignored");
`endif

endmodule
